// File: rtl/core/ldet_pkg.sv
// Shared widths, codes, control structs and the generator step of the leader election timer.
package ldet_pkg;

	localparam int unsigned ID_W      = 32;
	localparam int unsigned TERM_W    = 32;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned TMO_W     = 40;
	localparam int unsigned RNG_W     = 64;
	localparam int unsigned ACT_W     = 3;
	localparam int unsigned NOW_W     = 63;
	localparam int unsigned DL_W      = 64;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 64;

	localparam logic [ACT_W-1:0] ACT_START    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ANNOUNCE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_PROMOTE  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_ARM      = 3'd3;

	localparam logic [MODE_W-1:0] MODE_LEADER   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FOLLOWER = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_OWN_ID      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_MODE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TERM_BOOST  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MAX = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RNG_SEED    = 3'd5;

	typedef struct packed {
		logic capture;
		logic exec;
		logic sum;
		logic load_out;
	} ldet_cmd_t;

	typedef struct packed {
		logic need_arm;
		logic mod_done;
	} ldet_sts_t;

	function automatic logic [RNG_W-1:0] xorshift64(input logic [RNG_W-1:0] word);
		logic [RNG_W-1:0] x;
		x = word;
		x = x ^ (x << 13);
		x = x ^ (x >> 7);
		x = x ^ (x << 17);
		return x;
	endfunction

endpackage

// File: rtl/core/ldet_mod_unit.sv
// Bit-serial restoring remainder unit for the random part of the timeout.
module ldet_mod_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ldet_pkg::RNG_W-1:0]    dividend,
	input  logic [ldet_pkg::TMO_W-1:0]    divisor,
	output logic                          done,
	output logic [ldet_pkg::TMO_W-1:0]    rem
);

	localparam int unsigned CNT_W = $clog2(ldet_pkg::RNG_W);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [ldet_pkg::RNG_W-1:0] dvd_q;
	logic [ldet_pkg::TMO_W-1:0] dvs_q;
	logic [ldet_pkg::TMO_W-1:0] rem_q;
	logic [ldet_pkg::TMO_W:0]   trial;
	logic [ldet_pkg::TMO_W:0]   diff;

	assign trial = {rem_q, dvd_q[ldet_pkg::RNG_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ldet_pkg::RNG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ldet_pkg::RNG_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= diff[ldet_pkg::TMO_W-1:0];
			end else begin
				rem_q <= trial[ldet_pkg::TMO_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: rtl/core/ldet_dpath.sv
// Datapath: configuration registers, node state, item decision, deadline and result register.
module ldet_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ldet_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ldet_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  logic [ldet_pkg::ACT_W-1:0]       action,
	input  logic [ldet_pkg::TERM_W-1:0]      remote_term,
	input  logic [ldet_pkg::ID_W-1:0]        peer_id,
	input  logic [ldet_pkg::NOW_W-1:0]       now_time,
	input  ldet_pkg::ldet_cmd_t              cmd,
	output ldet_pkg::ldet_sts_t              sts,
	output logic                             verdict,
	output logic                             timed_out,
	output logic [ldet_pkg::TERM_W-1:0]      term_now,
	output logic [ldet_pkg::ID_W-1:0]        leader_now
);

	logic [ldet_pkg::ID_W-1:0]    own_id_q;
	logic [ldet_pkg::MODE_W-1:0]  lock_mode_q;
	logic [ldet_pkg::TERM_W-1:0]  term_boost_q;
	logic [ldet_pkg::TMO_W-1:0]   tmin_q;
	logic [ldet_pkg::TMO_W-1:0]   tmax_q;
	logic [ldet_pkg::RNG_W-1:0]   seed_q;

	logic [ldet_pkg::RNG_W-1:0]   rng_q;
	logic [ldet_pkg::TERM_W-1:0]  term_q;
	logic [ldet_pkg::ID_W-1:0]    leader_q;
	logic [ldet_pkg::DL_W-1:0]    deadline_q;

	logic [ldet_pkg::ACT_W-1:0]   act_q;
	logic [ldet_pkg::TERM_W-1:0]  pterm_q;
	logic [ldet_pkg::ID_W-1:0]    pid_q;
	logic [ldet_pkg::NOW_W-1:0]   now_q;
	logic [ldet_pkg::DL_W-1:0]    base_q;
	logic                         verdict_q;
	logic                         span_ok_q;

	logic                         out_verdict_q;
	logic                         out_timed_q;
	logic [ldet_pkg::TERM_W-1:0]  out_term_q;
	logic [ldet_pkg::ID_W-1:0]    out_leader_q;

	logic                         lock_leader;
	logic                         lock_follower;
	logic [ldet_pkg::TERM_W-1:0]  nxt_term;
	logic [ldet_pkg::ID_W-1:0]    nxt_leader;
	logic                         nxt_verdict;
	logic                         nxt_arm;
	logic                         nxt_seed;
	logic [ldet_pkg::RNG_W-1:0]   seed_or_one;
	logic [ldet_pkg::RNG_W-1:0]   rng_next;
	logic [ldet_pkg::TMO_W-1:0]   span;
	logic                         mod_done;
	logic [ldet_pkg::TMO_W-1:0]   mod_rem;
	logic [ldet_pkg::DL_W-1:0]    extra;

	assign lock_leader   = (lock_mode_q == ldet_pkg::MODE_LEADER);
	assign lock_follower = (lock_mode_q == ldet_pkg::MODE_FOLLOWER);
	assign seed_or_one   = (seed_q == '0) ? ldet_pkg::RNG_W'(1) : seed_q;
	assign rng_next      = ldet_pkg::xorshift64(nxt_seed ? seed_or_one : rng_q);
	assign span          = tmax_q - tmin_q;
	assign extra         = span_ok_q ? {{(ldet_pkg::DL_W-ldet_pkg::TMO_W){1'b0}}, mod_rem}
	                                 : '0;

	always_comb begin
		nxt_term    = term_q;
		nxt_leader  = leader_q;
		nxt_verdict = 1'b0;
		nxt_arm     = 1'b0;
		nxt_seed    = 1'b0;
		case (act_q)
			ldet_pkg::ACT_START: begin
				nxt_leader = '0;
				nxt_term   = lock_leader ? term_boost_q : '0;
				nxt_arm    = 1'b1;
				nxt_seed   = 1'b1;
			end
			ldet_pkg::ACT_ANNOUNCE: begin
				if (!lock_leader) begin
					if (pterm_q > term_q) begin
						nxt_term = pterm_q;
						if (pid_q <= own_id_q) begin
							nxt_leader  = pid_q;
							nxt_arm     = 1'b1;
							nxt_verdict = 1'b1;
						end
					end else if (pterm_q == term_q && pid_q < own_id_q) begin
						nxt_leader  = pid_q;
						nxt_arm     = 1'b1;
						nxt_verdict = 1'b1;
					end
				end
			end
			ldet_pkg::ACT_PROMOTE: begin
				nxt_term   = lock_leader ? term_boost_q : term_q + 1'b1;
				nxt_leader = own_id_q;
			end
			ldet_pkg::ACT_ARM: begin
				nxt_arm = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q     <= '0;
			lock_mode_q  <= '0;
			term_boost_q <= '0;
			tmin_q       <= '0;
			tmax_q       <= '0;
			seed_q       <= ldet_pkg::RNG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				ldet_pkg::REG_OWN_ID:      own_id_q     <= cfg_data[ldet_pkg::ID_W-1:0];
				ldet_pkg::REG_LOCK_MODE:   lock_mode_q  <= cfg_data[ldet_pkg::MODE_W-1:0];
				ldet_pkg::REG_TERM_BOOST:  term_boost_q <= cfg_data[ldet_pkg::TERM_W-1:0];
				ldet_pkg::REG_TIMEOUT_MIN: tmin_q       <= cfg_data[ldet_pkg::TMO_W-1:0];
				ldet_pkg::REG_TIMEOUT_MAX: tmax_q       <= cfg_data[ldet_pkg::TMO_W-1:0];
				ldet_pkg::REG_RNG_SEED:    seed_q       <= cfg_data[ldet_pkg::RNG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q      <= ldet_pkg::RNG_W'(1);
			term_q     <= '0;
			leader_q   <= '0;
			deadline_q <= '0;
		end else begin
			if (cmd.exec) begin
				term_q   <= nxt_term;
				leader_q <= nxt_leader;
				if (nxt_arm) begin
					rng_q <= rng_next;
				end
			end
			if (cmd.sum) begin
				deadline_q <= base_q + extra;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q   <= action;
			pterm_q <= remote_term;
			pid_q   <= peer_id;
			now_q   <= now_time;
		end
		if (cmd.exec) begin
			verdict_q <= nxt_verdict;
			span_ok_q <= (tmax_q > tmin_q);
			base_q    <= {{(ldet_pkg::DL_W-ldet_pkg::NOW_W){1'b0}}, now_q}
			           + {{(ldet_pkg::DL_W-ldet_pkg::TMO_W){1'b0}}, tmin_q};
		end
		if (cmd.load_out) begin
			out_verdict_q <= verdict_q;
			out_timed_q   <= !lock_follower
			               && ({{(ldet_pkg::DL_W-ldet_pkg::NOW_W){1'b0}}, now_q} >= deadline_q);
			out_term_q    <= term_q;
			out_leader_q  <= leader_q;
		end
	end

	ldet_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.exec && nxt_arm),
		.dividend (rng_next),
		.divisor  (span),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign sts.need_arm = nxt_arm;
	assign sts.mod_done = mod_done;

	assign verdict    = out_verdict_q;
	assign timed_out  = out_timed_q;
	assign term_now   = out_term_q;
	assign leader_now = out_leader_q;

endmodule

// File: rtl/core/ldet_ctrl.sv
// Controller state machine: input and output handshakes and the sequence of one item.
module ldet_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  ldet_pkg::ldet_sts_t sts,
	output ldet_pkg::ldet_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		cmd.capture  = 1'b0;
		cmd.exec     = 1'b0;
		cmd.sum      = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.need_arm ? ST_DIV : ST_FIN;
			end
			ST_DIV: begin
				if (sts.mod_done) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: rtl/core/leader_election_timer_unit.sv
// Top level of the leader election timer: controller, datapath and ports.
//
//   channel   direction   handshake               payload
//   input     in          in_valid / in_ready     action, remote_term, peer_id, now_time
//   result    out         out_valid / out_ready   verdict, timed_out, term_now, leader_now
//   config    in          cfg_we                  cfg_index, cfg_data
//
// An item that draws no new timeout goes through the execute and finish steps before the next beat is taken.
// An item that arms the timeout also passes the divide step, held for the bit-serial remainder unit, and the sum step.
// One item is in work at a time; the next beat is taken while a result waits in the output.
// A result that is not taken holds the last step, and the item behind it waits there.
// Reset is asynchronous and needs no clearing pass.
module leader_election_timer_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ldet_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ldet_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ldet_pkg::ACT_W-1:0]     action,
	input  logic [ldet_pkg::TERM_W-1:0]    remote_term,
	input  logic [ldet_pkg::ID_W-1:0]      peer_id,
	input  logic [ldet_pkg::NOW_W-1:0]     now_time,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           verdict,
	output logic                           timed_out,
	output logic [ldet_pkg::TERM_W-1:0]    term_now,
	output logic [ldet_pkg::ID_W-1:0]      leader_now
);

	ldet_pkg::ldet_cmd_t cmd;
	ldet_pkg::ldet_sts_t sts;

	ldet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ldet_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.action      (action),
		.remote_term (remote_term),
		.peer_id     (peer_id),
		.now_time    (now_time),
		.cmd         (cmd),
		.sts         (sts),
		.verdict     (verdict),
		.timed_out   (timed_out),
		.term_now    (term_now),
		.leader_now  (leader_now)
	);

endmodule

// File: rtl/core/ldet_checker.sv
// Port-level checker for the leader election timer and its bind to the top level.
module ldet_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [ldet_pkg::TERM_W-1:0] term_now,
	input logic [ldet_pkg::ID_W-1:0]   leader_now
);

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(term_now) && $stable(leader_now))
		else $error("result payload changed while stalled");

	// The unit works on a single item, so it is busy right after taking a beat.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again while an item is in work");

	// A new result only appears as the item finishes, which frees the input side.
	a_ready_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result appeared while an item was still in work");

endmodule

bind leader_election_timer_unit ldet_checker u_ldet_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.term_now   (term_now),
	.leader_now (leader_now)
);
